// File: hw/rtl/mipd_pkg.sv
package mipd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_PERIODIC_DIMS = 2'd0;
  localparam logic [1:0] REG_BOX_X         = 2'd1;
  localparam logic [1:0] REG_BOX_Y         = 2'd2;
  localparam logic [1:0] REG_BOX_Z         = 2'd3;

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned DIMS_W    = 2;

  // handshake status between a pipeline part and its queue
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

// File: hw/rtl/minimum_image_pair_distance_top.sv
// channel | direction | handshake         | word
// in      | in        | in_push / in_full | two positions, two tags
// out     | out       | out_pop/out_empty | distance, flags, tags
// cfg     | in        | cfg_we            | periodic_dims, box_x/y/z
// one word accepted per cycle while in_full is low;
// 4 front stages, middle queue, COORD_WIDTH root stages, out queue
// the back resolves one root bit per stage, so its depth is COORD_WIDTH
// reset is synchronous, active low; queues empty and boxes return to 1.0
// each part stalls only when its own output queue is full
module minimum_image_pair_distance_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mipd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-2:0]        cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [COORD_WIDTH-2:0] in_first_x,
  input  logic signed [COORD_WIDTH-2:0] in_first_y,
  input  logic signed [COORD_WIDTH-2:0] in_first_z,
  input  logic signed [COORD_WIDTH-2:0] in_second_x,
  input  logic signed [COORD_WIDTH-2:0] in_second_y,
  input  logic signed [COORD_WIDTH-2:0] in_second_z,
  input  logic [TAG_WIDTH-1:0]          in_first_tag,
  input  logic [TAG_WIDTH-1:0]          in_second_tag,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [COORD_WIDTH-1:0]        out_distance,
  output logic                          out_coincident,
  output logic                          out_wrap_overflow,
  output logic [TAG_WIDTH-1:0]          out_first_tag_out,
  output logic [TAG_WIDTH-1:0]          out_second_tag_out
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned MIDW = 2*CW + 1 + 2*TAG_WIDTH;
  localparam int unsigned OUTW = CW + 1 + 2*TAG_WIDTH;

  logic [mipd_pkg::DIMS_W-1:0] dims_r;
  logic [CW-2:0]               box_r [mipd_pkg::NUM_AXES];
  logic signed [CW-2:0]        first_c  [mipd_pkg::NUM_AXES];
  logic signed [CW-2:0]        second_c [mipd_pkg::NUM_AXES];

  mipd_pkg::q_wr_t      mid_wr, out_wr;
  logic                 mid_full, mid_empty, mid_pop, out_full;
  logic [2*CW-1:0]      f_sum;
  logic                 f_ovf;
  logic [TAG_WIDTH-1:0] f_ta, f_tb;
  logic [MIDW-1:0]      mid_rdata;
  logic [CW-1:0]        b_root;
  logic                 b_ovf;
  logic [TAG_WIDTH-1:0] b_ta, b_tb;
  logic [OUTW-1:0]      out_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= '0;
      for (int a = 0; a < mipd_pkg::NUM_AXES; a++) begin
        box_r[a] <= (CW-1)'(1) << FRAC_BITS;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        mipd_pkg::REG_PERIODIC_DIMS: dims_r   <= cfg_data[mipd_pkg::DIMS_W-1:0];
        mipd_pkg::REG_BOX_X:         box_r[0] <= cfg_data;
        mipd_pkg::REG_BOX_Y:         box_r[1] <= cfg_data;
        mipd_pkg::REG_BOX_Z:         box_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign first_c[0]  = in_first_x;
  assign first_c[1]  = in_first_y;
  assign first_c[2]  = in_first_z;
  assign second_c[0] = in_second_x;
  assign second_c[1] = in_second_y;
  assign second_c[2] = in_second_z;

  mipd_front #(.COORD_WIDTH(CW), .TAG_WIDTH(TAG_WIDTH)) u_front (
    .clk, .rst_n,
    .periodic_dims (dims_r),
    .box           (box_r),
    .in_push, .in_full,
    .first_c, .second_c,
    .first_tag     (in_first_tag),
    .second_tag    (in_second_tag),
    .q_wr_o        (mid_wr),
    .q_full        (mid_full),
    .sum_o         (f_sum),
    .ovf_o         (f_ovf),
    .first_tag_o   (f_ta),
    .second_tag_o  (f_tb)
  );

  // queue between front and back
  mipd_fifo #(.WIDTH(MIDW), .DEPTH(4)) u_mid_q (
    .clk, .rst_n,
    .push  (mid_wr.push),
    .wdata ({f_sum, f_ovf, f_ta, f_tb}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  mipd_back #(.COORD_WIDTH(CW), .TAG_WIDTH(TAG_WIDTH)) u_back (
    .clk, .rst_n,
    .q_empty      (mid_empty),
    .q_pop        (mid_pop),
    .sum_i        (mid_rdata[MIDW-1 -: 2*CW]),
    .ovf_i        (mid_rdata[2*TAG_WIDTH]),
    .first_tag_i  (mid_rdata[2*TAG_WIDTH-1 -: TAG_WIDTH]),
    .second_tag_i (mid_rdata[TAG_WIDTH-1:0]),
    .out_wr_o     (out_wr),
    .out_full     (out_full),
    .root_o       (b_root),
    .ovf_o        (b_ovf),
    .first_tag_o  (b_ta),
    .second_tag_o (b_tb)
  );

  // result queue
  mipd_fifo #(.WIDTH(OUTW), .DEPTH(2)) u_out_q (
    .clk, .rst_n,
    .push  (out_wr.push),
    .wdata ({b_root, b_ovf, b_ta, b_tb}),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_distance       = out_rdata[OUTW-1 -: CW];
  assign out_wrap_overflow  = out_rdata[2*TAG_WIDTH];
  assign out_first_tag_out  = out_rdata[2*TAG_WIDTH-1 -: TAG_WIDTH];
  assign out_second_tag_out = out_rdata[TAG_WIDTH-1:0];
  assign out_coincident     = (out_distance == '0);

  // back pops nothing from the middle queue while its word waits on a full result queue
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_wr.push && out_wr.full && !out_pop) || mid_pop == 1'b0)
    else $error("back pushed into full result queue");

  // front never pushes into a full middle queue without stalling input
  a_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_wr.push && mid_wr.full) |-> in_full)
    else $error("front did not stall on full middle queue");

  // result queue comes out of reset empty and input is not stalled
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

// File: hw/rtl/mipd_fifo.sv
module mipd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/mipd_front.sv
module mipd_front #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mipd_pkg::DIMS_W-1:0]   periodic_dims,
  input  logic [COORD_WIDTH-2:0]        box [mipd_pkg::NUM_AXES],
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [COORD_WIDTH-2:0] first_c [mipd_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-2:0] second_c [mipd_pkg::NUM_AXES],
  input  logic [TAG_WIDTH-1:0]          first_tag,
  input  logic [TAG_WIDTH-1:0]          second_tag,
  output mipd_pkg::q_wr_t               q_wr_o,
  input  logic                          q_full,
  output logic [2*COORD_WIDTH-1:0]      sum_o,
  output logic                          ovf_o,
  output logic [TAG_WIDTH-1:0]          first_tag_o,
  output logic [TAG_WIDTH-1:0]          second_tag_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NA = mipd_pkg::NUM_AXES;

  logic                 en;
  logic [4:1]           v_r;
  logic [TAG_WIDTH-1:0] t1a_r [4:1];
  logic [TAG_WIDTH-1:0] t1b_r [4:1];

  logic signed [CW-1:0] d_r [NA];
  logic [CW-2:0]        mag_r [NA];
  logic [2*CW-3:0]      sq_r [NA];
  logic [NA-1:0]        ovf_axis;
  logic                 ovf2_r, ovf3_r, ovf4_r;
  logic [2*CW-1:0]      sum_r;
  logic [CW-2:0]        mag_nxt [NA];

  // whole part advances unless the last word cannot leave
  assign en            = !v_r[4] || !q_full;
  assign in_full       = !en;
  assign q_wr_o.push   = v_r[4];
  assign q_wr_o.full   = q_full;
  assign sum_o         = sum_r;
  assign ovf_o         = ovf4_r;
  assign first_tag_o   = t1a_r[4];
  assign second_tag_o  = t1b_r[4];

  // single minimum-image correction per axis
  for (genvar a = 0; a < NA; a++) begin : g_wrap
    logic signed [CW+1:0] t2, lv;
    logic signed [CW:0]   v;
    logic signed [CW+2:0] tv, lw;
    logic                 per;
    always_comb begin
      per = (periodic_dims > mipd_pkg::DIMS_W'(a));
      t2  = {d_r[a][CW-1], d_r[a], 1'b0};
      lv  = signed'({3'b000, box[a]});
      v   = (CW+1)'(d_r[a]);
      if (per) begin
        if (t2 > lv) begin
          v = (CW+1)'(d_r[a]) - signed'({2'b00, box[a]});
        end else if (t2 < -lv) begin
          v = (CW+1)'(d_r[a]) + signed'({2'b00, box[a]});
        end
      end
      tv = {v[CW], v, 1'b0};
      lw = signed'({4'b0000, box[a]});
      ovf_axis[a] = per && ((tv > lw) || (tv < -lw));
      mag_nxt[a]  = v[CW] ? (CW-1)'(-v) : (CW-1)'(v);
    end
  end

  // difference, correction, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        d_r[a]   <= CW'(first_c[a]) - CW'(second_c[a]);
        mag_r[a] <= mag_nxt[a];
        sq_r[a]  <= mag_r[a] * mag_r[a];
      end
      ovf2_r <= |ovf_axis;
      ovf3_r <= ovf2_r;
      ovf4_r <= ovf3_r;
      sum_r  <= (2*CW)'(sq_r[0]) + (2*CW)'(sq_r[1]) + (2*CW)'(sq_r[2]);
      t1a_r[1] <= first_tag;
      t1b_r[1] <= second_tag;
      for (int s = 2; s <= 4; s++) begin
        t1a_r[s] <= t1a_r[s-1];
        t1b_r[s] <= t1b_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:1], in_push};
    end
  end

endmodule

// File: hw/rtl/mipd_back.sv
module mipd_back #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [2*COORD_WIDTH-1:0] sum_i,
  input  logic                     ovf_i,
  input  logic [TAG_WIDTH-1:0]     first_tag_i,
  input  logic [TAG_WIDTH-1:0]     second_tag_i,
  output mipd_pkg::q_wr_t          out_wr_o,
  input  logic                     out_full,
  output logic [COORD_WIDTH-1:0]   root_o,
  output logic                     ovf_o,
  output logic [TAG_WIDTH-1:0]     first_tag_o,
  output logic [TAG_WIDTH-1:0]     second_tag_o
);

  localparam int unsigned CW = COORD_WIDTH;

  logic                 en;
  logic [CW:0]          v;
  logic [2*CW:0]        rem  [CW+1];
  logic [CW-1:0]        root [CW+1];
  logic                 ovf  [CW+1];
  logic [TAG_WIDTH-1:0] ta   [CW+1];
  logic [TAG_WIDTH-1:0] tb   [CW+1];

  assign en            = !v[CW] || !out_full;
  assign q_pop         = en && !q_empty;
  assign out_wr_o.push = v[CW];
  assign out_wr_o.full = out_full;
  assign root_o        = root[CW];
  assign ovf_o         = ovf[CW];
  assign first_tag_o   = ta[CW];
  assign second_tag_o  = tb[CW];

  // queue head feeds the first root stage
  assign v[0]    = !q_empty;
  assign rem[0]  = {1'b0, sum_i};
  assign root[0] = '0;
  assign ovf[0]  = ovf_i;
  assign ta[0]   = first_tag_i;
  assign tb[0]   = second_tag_i;

  // one root bit per stage, most significant first
  for (genvar i = 0; i < CW; i++) begin : g_root
    localparam int unsigned B = CW - 1 - i;
    logic [2*CW:0] delta;
    logic          take;
    logic [2*CW:0] rem_r;
    logic [CW-1:0] root_r;
    logic          ovf_r, v_r;
    logic [TAG_WIDTH-1:0] ta_r, tb_r;
    always_comb begin
      delta = (((2*CW+1)'(root[i])) << (B + 1)) + ((2*CW+1)'(1) << (2 * B));
      take  = (rem[i] >= delta);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= take ? rem[i] - delta : rem[i];
        root_r <= take ? (root[i] | (CW'(1) << B)) : root[i];
        ovf_r  <= ovf[i];
        ta_r   <= ta[i];
        tb_r   <= tb[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v[i];
      end
    end
    assign v[i+1]    = v_r;
    assign rem[i+1]  = rem_r;
    assign root[i+1] = root_r;
    assign ovf[i+1]  = ovf_r;
    assign ta[i+1]   = ta_r;
    assign tb[i+1]   = tb_r;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CW = 32;
  localparam int TW = 16;
  localparam int CB = CW - 1;

  typedef struct packed {
    logic [CW-1:0] distance;
    logic          coincident;
    logic          wrap_overflow;
    logic [TW-1:0] first_tag;
    logic [TW-1:0] second_tag;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mipd_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [CB-1:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [CB-1:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic [TW-1:0] in_first_tag = '0, in_second_tag = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [CW-1:0] out_distance;
  logic out_coincident, out_wrap_overflow;
  logic [TW-1:0] out_first_tag_out, out_second_tag_out;

  // predictor copy of the registers
  logic [1:0]    dims_q;
  logic [CB-1:0] box_q [3];

  dist_word_t pending_dist_q[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  minimum_image_pair_distance_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("minimum_image_pair_distance_top: mismatch");
    $finish;
  end

  // 128-bit sum of squares and its integer root
  function automatic logic [CW-1:0] isqrt128(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) root = cand;
    end
    if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
    return root[CW-1:0];
  endfunction

  function automatic dist_word_t predict_distance(
      logic signed [CB-1:0] ax, ay, az, bx, by, bz, logic [TW-1:0] ta, tb_);
    longint d [3];
    longint lb;
    logic [127:0] sum;
    logic [63:0] m;
    dist_word_t w;
    d[0] = longint'(ax) - longint'(bx);
    d[1] = longint'(ay) - longint'(by);
    d[2] = longint'(az) - longint'(bz);
    w.wrap_overflow = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (a < dims_q) begin
        lb = longint'({1'b0, box_q[a]});
        if (2 * d[a] > lb) d[a] -= lb;
        else if (2 * d[a] < -lb) d[a] += lb;
        if ((2 * d[a] > lb) || (2 * d[a] < -lb)) w.wrap_overflow = 1'b1;
      end
    end
    sum = '0;
    for (int a = 0; a < 3; a++) begin
      m = (d[a] < 0) ? 64'(-d[a]) : 64'(d[a]);
      sum += {64'd0, m} * {64'd0, m};
    end
    w.distance = isqrt128(sum);
    w.coincident = (w.distance == 0);
    w.first_tag = ta;
    w.second_tag = tb_;
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    dist_word_t exp_w;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_dist_q.size() == 0) begin
        $error("unexpected word distance=%0h", out_distance);
        fail_count++;
      end else begin
        exp_w = pending_dist_q.pop_front();
        if (out_distance !== exp_w.distance) begin
          $error("distance exp %0h got %0h", exp_w.distance, out_distance);
          fail_count++;
        end
        if (out_coincident !== exp_w.coincident) begin
          $error("coincident exp %0b got %0b", exp_w.coincident, out_coincident);
          fail_count++;
        end
        if (out_wrap_overflow !== exp_w.wrap_overflow) begin
          $error("wrap_overflow exp %0b got %0b", exp_w.wrap_overflow,
                 out_wrap_overflow);
          fail_count++;
        end
        if (out_first_tag_out !== exp_w.first_tag) begin
          $error("first_tag_out exp %0h got %0h", exp_w.first_tag, out_first_tag_out);
          fail_count++;
        end
        if (out_second_tag_out !== exp_w.second_tag) begin
          $error("second_tag_out exp %0h got %0h", exp_w.second_tag,
                 out_second_tag_out);
          fail_count++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic write_reg(logic [mipd_pkg::REG_IDX_W-1:0] idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mipd_pkg::REG_PERIODIC_DIMS: dims_q = val[1:0];
      mipd_pkg::REG_BOX_X: box_q[0] = val;
      mipd_pkg::REG_BOX_Y: box_q[1] = val;
      default: box_q[2] = val;
    endcase
  endtask

  task automatic set_box(logic [1:0] dims, logic [CB-1:0] bx, by, bz);
    write_reg(mipd_pkg::REG_PERIODIC_DIMS, {29'd0, dims});
    write_reg(mipd_pkg::REG_BOX_X, bx);
    write_reg(mipd_pkg::REG_BOX_Y, by);
    write_reg(mipd_pkg::REG_BOX_Z, bz);
  endtask

  // send one word, with random idle before it; push stays high until idle or drain
  task automatic send_pair(logic signed [CB-1:0] ax, ay, az, bx, by, bz,
                           logic [TW-1:0] ta, tb_);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_first_x <= ax; in_first_y <= ay; in_first_z <= az;
    in_second_x <= bx; in_second_y <= by; in_second_z <= bz;
    in_first_tag <= ta; in_second_tag <= tb_;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_dist_q.push_back(predict_distance(ax, ay, az, bx, by, bz, ta, tb_));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] rand_coord(logic [CB-1:0] span);
    logic [CB-1:0] r;
    case ($urandom_range(3))
      0: r = CB'($urandom);
      1: r = CB'($urandom_range(1) ? -1 : 0) ^ CB'($urandom_range(15));
      default: r = CB'($urandom) % ((span == 0) ? 1 : span * 2 + 1) - span;
    endcase
    return r;
  endfunction

  task automatic test_directed();
    localparam logic signed [CB-1:0] MAXC = 31'sh3FFF_FFFF;
    localparam logic signed [CB-1:0] MINC = 31'sh4000_0000;
    set_box(2'd0, 31'h10000, 31'h10000, 31'h10000);
    send_pair(0, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF);
    send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC, 16'hFFFF, 16'h0000);
    send_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, 16'hA5A5, 16'h5A5A);
    send_pair(31'sh30000, 31'sh40000, 0, 0, 0, 0, 16'd1, 16'd2);
    drain();
    set_box(2'd3, 31'h40000, 31'h40000, 31'h40000);
    // exactly half a box, plus and minus
    send_pair(31'sh20000, 0, 0, 0, 0, 0, 16'd3, 16'd4);
    send_pair(0, 31'sh20000, 0, 0, 0, 0, 16'd5, 16'd6);
    send_pair(0, 0, 0, 0, 0, 31'sh20000, 16'd7, 16'd8);
    send_pair(31'sh20001, 0, 0, 0, 0, 0, 16'd9, 16'd10);
    // far difference, one correction only
    send_pair(MAXC, MINC, MAXC, MINC, MAXC, MINC, 16'd11, 16'd12);
    send_pair(31'sh40000, 31'sh40000, 31'sh40000, 0, 0, 0, 16'd13, 16'd14);
    drain();
    // zero box
    set_box(2'd3, 31'd0, 31'd0, 31'd0);
    send_pair(0, 0, 0, 0, 0, 0, 16'd15, 16'd16);
    send_pair(1, 0, 0, 0, 0, 0, 16'd17, 16'd18);
    send_pair(0, 0, -1, 0, 0, 0, 16'd19, 16'd20);
    drain();
    set_box(2'd1, 31'h4000_0000, 31'd1, 31'h7FFF_FFFF);
    send_pair(MAXC, MAXC, MAXC, MINC, MINC, MINC, 16'd21, 16'd22);
    send_pair(MINC, 1, 1, MAXC, 0, 0, 16'd23, 16'd24);
    drain();
    set_box(2'd2, 31'd1, 31'd1, 31'd1);
    send_pair(1, 1, 1, 0, 0, 0, 16'd25, 16'd26);
    send_pair(-1, -1, 5, 0, 0, 0, 16'd27, 16'd28);
    drain();
  endtask

  task automatic test_random(int count);
    logic [CB-1:0] span;
    for (int p = 0; p < count; p++) begin
      if (p % 50 == 0) begin
        drain();
        span = ($urandom_range(3) == 0) ? 31'h3FFF_FFFF : CB'($urandom_range(1 << 22));
        set_box(2'($urandom_range(3)),
                ($urandom_range(7) == 0) ? CB'($urandom) : span + CB'($urandom_range(9)),
                ($urandom_range(7) == 0) ? 31'h4000_0000 : span,
                ($urandom_range(7) == 0) ? 31'd1 : span + 1);
        case ((p / 50) % 4)
          0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
          1: begin send_idle_pct = 64; pop_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  pop_stall_pct = 64; end
          default: begin send_idle_pct = 22; pop_stall_pct = 22; end
        endcase
      end
      send_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                rand_coord(span), rand_coord(span), rand_coord(span),
                TW'($urandom), TW'($urandom));
    end
    drain();
  endtask

  initial begin
    dims_q = '0;
    box_q[0] = 31'h10000; box_q[1] = 31'h10000; box_q[2] = 31'h10000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(850);
    if (fail_count == 0 && pending_dist_q.size() == 0) begin
      $display("minimum_image_pair_distance_top: match");
    end else begin
      $display("minimum_image_pair_distance_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mipd_pkg.sv
hw/rtl/mipd_fifo.sv
hw/rtl/mipd_front.sv
hw/rtl/mipd_back.sv
hw/rtl/minimum_image_pair_distance_top.sv
dv/tb.sv
